>>> rtl/tft_pkg.sv
// Package with shared types, constants and codes of the TCP flow tracker.
package tft_pkg;

    localparam int DEF_FLOW_ENTRIES = 256;
    localparam logic [15:0] DEF_CLIENT_PORT_THRESHOLD = 16'd1024;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] FLG_FIN = 8'h01;
    localparam logic [7:0] FLG_SYN = 8'h02;
    localparam logic [7:0] FLG_RST = 8'h04;
    localparam logic [7:0] FLG_PSH = 8'h08;
    localparam logic [7:0] FLG_ACK = 8'h10;

    localparam logic [2:0] HS_ALL = 3'b111;

    localparam logic REC_CLOSED     = 1'b0;
    localparam logic REC_TABLE_FULL = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_INSERT = 2'd3
    } tft_op_t;

    typedef struct packed {
        logic [31:0] client_address;
        logic [31:0] server_address;
        logic [15:0] client_side_port;
        logic [15:0] server_side_port;
    } tft_key_t;

    typedef struct packed {
        tft_op_t     op;
        tft_key_t    key;
        logic [47:0] client_mac;
        logic [31:0] seconds;
        logic [15:0] length;
    } tft_cmd_t;

    typedef struct packed {
        tft_key_t    key;
        logic [47:0] client_mac;
        logic [31:0] start_seconds;
        logic [39:0] byte_total;
        logic [31:0] packet_total;
    } tft_entry_t;

endpackage

>>> rtl/tft_ifs.sv
// Valid/ready channel interfaces for packet headers and flow records.
interface tft_pkt_if;
    logic        valid;
    logic        ready;
    logic [47:0] source_mac;
    logic [47:0] destination_mac;
    logic [31:0] source_ip;
    logic [31:0] destination_ip;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  tcp_flags;
    logic [15:0] captured_length;
    logic [31:0] timestamp_seconds;

    modport source (output valid, source_mac, destination_mac, source_ip, destination_ip,
                    source_port, destination_port, tcp_flags, captured_length,
                    timestamp_seconds, input ready);
    modport sink (input valid, source_mac, destination_mac, source_ip, destination_ip,
                  source_port, destination_port, tcp_flags, captured_length,
                  timestamp_seconds, output ready);
endinterface

interface tft_rec_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [47:0] client_mac;
    logic [31:0] client_address;
    logic [31:0] server_address;
    logic [15:0] client_side_port;
    logic [15:0] server_side_port;
    logic [31:0] start_seconds;
    logic [31:0] end_seconds;
    logic [39:0] byte_total;
    logic [31:0] packet_total;

    modport source (output valid, record_kind, client_mac, client_address, server_address,
                    client_side_port, server_side_port, start_seconds, end_seconds,
                    byte_total, packet_total, input ready);
    modport sink (input valid, record_kind, client_mac, client_address, server_address,
                  client_side_port, server_side_port, start_seconds, end_seconds,
                  byte_total, packet_total, output ready);
endinterface

>>> rtl/tcp_flow_tracker_core.sv
// Top level of the TCP flow tracker: threshold register, front end, queue and table engine.
// The block keeps a table of FLOW_ENTRIES TCP flows with saturating byte and packet
// counters and emits a record when a counted flow closes or when an insert finds the
// table full. Flag-only headers (no push, close or insert) are absorbed by the front end.
// Every other header is a table command, resolved by a linear scan of the flow memory,
// one entry per cycle; a lookup that hits stops the scan early. A two-word queue lets
// headers be accepted while the scan runs, and a result register lets the next command
// start while a record waits.
module tcp_flow_tracker_core #(
    parameter int FLOW_ENTRIES = tft_pkg::DEF_FLOW_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    tft_pkt_if.sink     pkt,
    tft_rec_if.source   rec
);
    import tft_pkg::*;

    logic [15:0] threshold_reg;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    tft_cmd_t    push_cmd;
    tft_cmd_t    pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= DEF_CLIENT_PORT_THRESHOLD;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    tft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .pkt       (pkt),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    tft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tft_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .rec     (rec)
    );

endmodule

>>> rtl/tft_front.sv
// Front end: orients the key, tracks handshake flags and issues table commands.
module tft_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     threshold,
    tft_pkt_if.sink         pkt,
    input  logic            q_full,
    output logic            q_push,
    output tft_pkg::tft_cmd_t q_cmd
);
    import tft_pkg::*;

    logic [2:0] hs_reg;
    logic [2:0] hs_next;
    logic       is_client;
    tft_op_t    op;

    assign is_client = pkt.source_port > threshold;
    assign pkt.ready = !q_full;

    always_comb
    begin
        hs_next = hs_reg;
        op      = OP_NONE;
        if (pkt.tcp_flags == FLG_SYN)
        begin
            hs_next = hs_reg | 3'b001;
        end
        else if (pkt.tcp_flags == (FLG_SYN | FLG_ACK))
        begin
            hs_next = hs_reg | 3'b010;
        end
        else if (pkt.tcp_flags == FLG_ACK)
        begin
            hs_next = hs_reg | 3'b100;
        end
        else if (pkt.tcp_flags == (FLG_FIN | FLG_ACK) || pkt.tcp_flags == FLG_RST)
        begin
            hs_next = 3'b000;
            op      = OP_CLOSE;
        end
        else if (pkt.tcp_flags == (FLG_PSH | FLG_ACK))
        begin
            hs_next = 3'b000;
            op      = OP_PUSH;
        end
        // A close or push clears the flags, so only a flag-only word can insert.
        if (op == OP_NONE && hs_next == HS_ALL)
        begin
            op = OP_INSERT;
        end
    end

    always_comb
    begin
        q_cmd.op = op;
        if (is_client)
        begin
            q_cmd.key.client_address   = pkt.source_ip;
            q_cmd.key.server_address   = pkt.destination_ip;
            q_cmd.key.client_side_port = pkt.source_port;
            q_cmd.key.server_side_port = pkt.destination_port;
            q_cmd.client_mac           = pkt.source_mac;
        end
        else
        begin
            q_cmd.key.client_address   = pkt.destination_ip;
            q_cmd.key.server_address   = pkt.source_ip;
            q_cmd.key.client_side_port = pkt.destination_port;
            q_cmd.key.server_side_port = pkt.source_port;
            q_cmd.client_mac           = pkt.destination_mac;
        end
        q_cmd.seconds = pkt.timestamp_seconds;
        q_cmd.length  = pkt.captured_length;
    end

    assign q_push = pkt.valid && !q_full && op != OP_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg <= 3'b000;
        end
        else if (pkt.valid && !q_full)
        begin
            hs_reg <= hs_next;
        end
    end

endmodule

>>> rtl/tft_queue.sv
// Short command queue between the front end and the table engine.
module tft_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tft_pkg::tft_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output tft_pkg::tft_cmd_t pop_cmd,
    output logic              empty
);
    import tft_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tft_cmd_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tft_back.sv
// Table engine: scans the flow memory, updates entries and emits flow records.
module tft_back #(
    parameter int FLOW_ENTRIES = tft_pkg::DEF_FLOW_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  tft_pkg::tft_cmd_t q_cmd,
    output logic              q_pop,
    tft_rec_if.source         rec
);
    import tft_pkg::*;

    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg;
    tft_cmd_t            cmd_reg;
    tft_entry_t          mem [FLOW_ENTRIES];
    tft_entry_t          rd_data_reg;
    tft_entry_t          hit_data_reg;
    logic [FLOW_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic                issue_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_vld_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic                match;
    logic                emit;
    logic                stall;
    logic                finish;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    tft_entry_t          wr_data;
    logic [40:0]         byte_sum;
    logic                out_valid_reg;
    logic                out_kind_reg;
    tft_entry_t          out_data_reg;
    logic [31:0]         out_end_reg;

    assign match = cmp_vld_reg && valid_reg[cmp_idx_reg] && rd_data_reg.key == cmd_reg.key;
    assign byte_sum = {1'b0, hit_data_reg.byte_total} + 41'(cmd_reg.length);

    always_comb
    begin
        emit = 1'b0;
        if (cmd_reg.op == OP_CLOSE && hit_reg && hit_data_reg.packet_total != '0)
        begin
            emit = 1'b1;
        end
        if (cmd_reg.op == OP_INSERT && !hit_reg && !free_found_reg)
        begin
            emit = 1'b1;
        end
    end

    assign stall  = emit && out_valid_reg && !rec.ready;
    assign finish = state_reg == ST_DONE && !stall;
    assign q_pop  = state_reg == ST_IDLE && !q_empty;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data = hit_data_reg;
        if (finish && cmd_reg.op == OP_PUSH && hit_reg)
        begin
            wr_en              = 1'b1;
            wr_data.byte_total = byte_sum[40] ? '1 : byte_sum[39:0];
            if (hit_data_reg.packet_total != '1)
            begin
                wr_data.packet_total = hit_data_reg.packet_total + 1'b1;
            end
        end
        else if (finish && cmd_reg.op == OP_INSERT && !hit_reg && free_found_reg)
        begin
            wr_en                 = 1'b1;
            wr_addr               = free_idx_reg;
            wr_data.key           = cmd_reg.key;
            wr_data.client_mac    = cmd_reg.client_mac;
            wr_data.start_seconds = cmd_reg.seconds;
            wr_data.byte_total    = '0;
            wr_data.packet_total  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == ST_SCAN && match)
        begin
            hit_data_reg <= rd_data_reg;
            hit_idx_reg  <= cmp_idx_reg;
        end
        if (state_reg == ST_SCAN && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (finish && emit)
        begin
            out_kind_reg <= (cmd_reg.op == OP_CLOSE) ? REC_CLOSED : REC_TABLE_FULL;
            out_end_reg  <= (cmd_reg.op == OP_CLOSE) ? cmd_reg.seconds : 32'd0;
            if (cmd_reg.op == OP_CLOSE)
            begin
                out_data_reg <= hit_data_reg;
            end
            else
            begin
                out_data_reg.key           <= cmd_reg.key;
                out_data_reg.client_mac    <= cmd_reg.client_mac;
                out_data_reg.start_seconds <= cmd_reg.seconds;
                out_data_reg.byte_total    <= '0;
                out_data_reg.packet_total  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            addr_reg       <= '0;
            issue_reg      <= 1'b0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (finish && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rec.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        addr_reg       <= '0;
                        issue_reg      <= 1'b1;
                        cmp_vld_reg    <= 1'b0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // Reads are issued one entry ahead of the compare stage.
                    cmp_idx_reg <= addr_reg;
                    cmp_vld_reg <= issue_reg;
                    if (issue_reg)
                    begin
                        addr_reg <= addr_reg + 1'b1;
                        if (addr_reg == LAST_IDX)
                        begin
                            issue_reg <= 1'b0;
                        end
                    end
                    if (cmp_vld_reg && !valid_reg[cmp_idx_reg])
                    begin
                        free_found_reg <= 1'b1;
                    end
                    if (match)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else if (cmp_vld_reg && cmp_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!stall)
                    begin
                        if (cmd_reg.op == OP_CLOSE && hit_reg)
                        begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                        end
                        if (cmd_reg.op == OP_INSERT && !hit_reg && free_found_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rec.valid            = out_valid_reg;
    assign rec.record_kind      = out_kind_reg;
    assign rec.client_mac       = out_data_reg.client_mac;
    assign rec.client_address   = out_data_reg.key.client_address;
    assign rec.server_address   = out_data_reg.key.server_address;
    assign rec.client_side_port = out_data_reg.key.client_side_port;
    assign rec.server_side_port = out_data_reg.key.server_side_port;
    assign rec.start_seconds    = out_data_reg.start_seconds;
    assign rec.end_seconds      = out_end_reg;
    assign rec.byte_total       = out_data_reg.byte_total;
    assign rec.packet_total     = out_data_reg.packet_total;

endmodule

>>> dv/tb_tcp_flow_tracker_core.sv
// Testbench for tcp_flow_tracker_core: directed and random header streams checked per record.
module tb_tcp_flow_tracker_core;
    import tft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = DEF_FLOW_ENTRIES;
    localparam int SETTLE_CYCLES = 3 * (ENTRIES + 4) + 50;
    localparam int WATCHDOG_LIMIT = 40 * (ENTRIES + 4) + 2000;

    typedef struct packed {
        logic [47:0] source_mac;
        logic [47:0] destination_mac;
        logic [31:0] source_ip;
        logic [31:0] destination_ip;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  tcp_flags;
        logic [15:0] captured_length;
        logic [31:0] timestamp_seconds;
    } header_t;

    typedef struct packed {
        logic        record_kind;
        logic [47:0] client_mac;
        logic [31:0] client_address;
        logic [31:0] server_address;
        logic [15:0] client_side_port;
        logic [15:0] server_side_port;
        logic [31:0] start_seconds;
        logic [31:0] end_seconds;
        logic [39:0] byte_total;
        logic [31:0] packet_total;
    } flow_rec_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [15:0] cfg_wr_data;

    tft_pkt_if pkt();
    tft_rec_if rec();

    tcp_flow_tracker_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pkt(pkt),
        .rec(rec)
    );

    // Shadow copy of the flow table and the shared handshake flags.
    logic [15:0] port_threshold;
    logic [2:0]  hs_flags;
    logic        slot_used [ENTRIES];
    tft_key_t    slot_key [ENTRIES];
    logic [47:0] slot_mac [ENTRIES];
    logic [31:0] slot_start [ENTRIES];
    logic [39:0] slot_bytes [ENTRIES];
    logic [31:0] slot_packets [ENTRIES];

    flow_rec_t expected_records[$];
    int  error_count;
    int  quiet_cycles;
    bit  no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int find_slot(tft_key_t k);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < ENTRIES; i++)
            if (!slot_used[i])
                return i;
        return -1;
    endfunction

    // Updates the shadow table for one accepted header and queues any record it causes.
    function automatic void track_header(header_t h);
        tft_key_t    k;
        logic [47:0] cmac;
        flow_rec_t   r;
        bit          emitted;
        int          idx;
        logic [40:0] sum;
        emitted = 0;
        if (h.source_port > port_threshold)
        begin
            cmac = h.source_mac;
            k = '{h.source_ip, h.destination_ip, h.source_port, h.destination_port};
        end
        else
        begin
            cmac = h.destination_mac;
            k = '{h.destination_ip, h.source_ip, h.destination_port, h.source_port};
        end
        if (h.tcp_flags == FLG_SYN)
            hs_flags[0] = 1'b1;
        else if (h.tcp_flags == (FLG_SYN | FLG_ACK))
            hs_flags[1] = 1'b1;
        else if (h.tcp_flags == FLG_ACK)
            hs_flags[2] = 1'b1;
        else if (h.tcp_flags == (FLG_FIN | FLG_ACK) || h.tcp_flags == FLG_RST)
        begin
            idx = find_slot(k);
            if (idx >= 0)
            begin
                if (slot_packets[idx] != 0)
                begin
                    r = '{REC_CLOSED, slot_mac[idx], slot_key[idx].client_address,
                          slot_key[idx].server_address, slot_key[idx].client_side_port,
                          slot_key[idx].server_side_port, slot_start[idx],
                          h.timestamp_seconds, slot_bytes[idx], slot_packets[idx]};
                    expected_records.push_back(r);
                    emitted = 1;
                end
                slot_used[idx] = 1'b0;
            end
            hs_flags = '0;
        end
        else if (h.tcp_flags == (FLG_PSH | FLG_ACK))
        begin
            idx = find_slot(k);
            if (idx >= 0)
            begin
                sum = {1'b0, slot_bytes[idx]} + 41'(h.captured_length);
                slot_bytes[idx] = sum[40] ? '1 : sum[39:0];
                if (slot_packets[idx] != '1)
                    slot_packets[idx] = slot_packets[idx] + 32'd1;
            end
            hs_flags = '0;
        end
        if (hs_flags == HS_ALL && find_slot(k) < 0)
        begin
            idx = free_slot();
            if (idx >= 0)
            begin
                slot_used[idx] = 1'b1;
                slot_key[idx] = k;
                slot_mac[idx] = cmac;
                slot_start[idx] = h.timestamp_seconds;
                slot_bytes[idx] = '0;
                slot_packets[idx] = '0;
            end
            else if (!emitted)
            begin
                r = '{REC_TABLE_FULL, cmac, k.client_address, k.server_address,
                      k.client_side_port, k.server_side_port, h.timestamp_seconds,
                      32'd0, 40'd0, 32'd0};
                expected_records.push_back(r);
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is accepted.
    task automatic send_header(header_t h);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            pkt.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        pkt.valid <= 1'b1;
        pkt.source_mac <= h.source_mac;
        pkt.destination_mac <= h.destination_mac;
        pkt.source_ip <= h.source_ip;
        pkt.destination_ip <= h.destination_ip;
        pkt.source_port <= h.source_port;
        pkt.destination_port <= h.destination_port;
        pkt.tcp_flags <= h.tcp_flags;
        pkt.captured_length <= h.captured_length;
        pkt.timestamp_seconds <= h.timestamp_seconds;
        do
            @(posedge clk);
        while (!pkt.ready);
        track_header(h);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pkt.valid <= 1'b0;
        while (expected_records.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        port_threshold = value;
    endtask

    function automatic header_t random_header();
        header_t      h;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        h = raw[$bits(header_t)-1:0];
        return h;
    endfunction

    // Builds a header of one flow; from_client picks which side sends it.
    function automatic header_t flow_header(tft_key_t k, logic [47:0] cmac, logic [47:0] smac,
                                            bit from_client, logic [7:0] flags);
        header_t h;
        h = random_header();
        h.tcp_flags = flags;
        if (from_client)
        begin
            h.source_mac = cmac;
            h.destination_mac = smac;
            h.source_ip = k.client_address;
            h.destination_ip = k.server_address;
            h.source_port = k.client_side_port;
            h.destination_port = k.server_side_port;
        end
        else
        begin
            h.source_mac = smac;
            h.destination_mac = cmac;
            h.source_ip = k.server_address;
            h.destination_ip = k.client_address;
            h.source_port = k.server_side_port;
            h.destination_port = k.client_side_port;
        end
        return h;
    endfunction

    function automatic tft_key_t random_key();
        tft_key_t k;
        k.client_address = $urandom;
        k.server_address = $urandom;
        k.client_side_port = (port_threshold == 16'hffff) ? 16'($urandom)
                             : 16'($urandom_range(int'(port_threshold) + 1, 65535));
        k.server_side_port = 16'($urandom_range(0, int'(port_threshold)));
        return k;
    endfunction

    task automatic open_flow(tft_key_t k, logic [47:0] cmac, logic [47:0] smac);
        send_header(flow_header(k, cmac, smac, 1'b1, FLG_SYN));
        send_header(flow_header(k, cmac, smac, 1'b0, FLG_SYN | FLG_ACK));
        send_header(flow_header(k, cmac, smac, 1'b1, FLG_ACK));
    endtask

    task automatic test_directed();
        tft_key_t k;
        header_t  h;
        k = '{32'hffff_ffff, 32'h0000_0000, 16'hffff, 16'h0000};
        open_flow(k, 48'hffff_ffff_ffff, 48'h0);
        h = flow_header(k, 48'hffff_ffff_ffff, 48'h0, 1'b1, FLG_PSH | FLG_ACK);
        h.captured_length = 16'hffff;
        send_header(h);
        h = flow_header(k, 48'hffff_ffff_ffff, 48'h0, 1'b0, FLG_PSH | FLG_ACK);
        h.captured_length = 16'h0;
        send_header(h);
        h = flow_header(k, 48'hffff_ffff_ffff, 48'h0, 1'b0, FLG_FIN | FLG_ACK);
        h.timestamp_seconds = 32'hffff_ffff;
        send_header(h);
        // A flow that closes with no data sends nothing.
        k = '{32'h0a00_0001, 32'h0a00_0002, 16'd1025, 16'd1024};
        open_flow(k, 48'h0200_0000_0001, 48'h0200_0000_0002);
        send_header(flow_header(k, 48'h1, 48'h2, 1'b1, FLG_RST));
        // Data and close on a key that is not in the table.
        send_header(flow_header(k, 48'h1, 48'h2, 1'b1, FLG_PSH | FLG_ACK));
        send_header(flow_header(k, 48'h1, 48'h2, 1'b0, FLG_FIN | FLG_ACK));
        // With all flags set, a flag byte with extra bits still inserts its key.
        open_flow(random_key(), 48'h3, 48'h4);
        send_header(flow_header(random_key(), 48'h5, 48'h6, 1'b1, 8'h52));
        send_header(flow_header(random_key(), 48'h7, 48'h8, 1'b0, 8'hff));
        h = random_header();
        h.tcp_flags = FLG_RST;
        send_header(h);
        wait_idle();
    endtask

    task automatic test_table_full();
        tft_key_t keys[$];
        tft_key_t k;
        open_flow(random_key(), 48'h9, 48'ha);
        // Unmatched flag bytes keep the flags set, so each new key is inserted
        // until the table runs out of slots.
        for (int i = 0; i < ENTRIES + 6; i++)
        begin
            k = random_key();
            keys.push_back(k);
            send_header(flow_header(k, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                    1'b1, 8'h00));
        end
        foreach (keys[i])
            send_header(flow_header(keys[i], 48'h0, 48'h0, 1'b1, FLG_RST));
        wait_idle();
        // Clear every slot still in use, such as the one the first handshake inserted.
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i])
                send_header(flow_header(slot_key[i], 48'h0, 48'h0, 1'b1, FLG_RST));
        wait_idle();
    endtask

    task automatic test_random_flows(int flows);
        tft_key_t    k;
        logic [47:0] cmac;
        logic [47:0] smac;
        int          npush;
        for (int f = 0; f < flows; f++)
        begin
            no_idle = ($urandom_range(0, 9) == 0);
            k = random_key();
            cmac = 48'({$urandom, $urandom});
            smac = 48'({$urandom, $urandom});
            if ($urandom_range(0, 9) == 0)
                send_header(random_header());
            if ($urandom_range(0, 9) != 0)
                open_flow(k, cmac, smac);
            else
                send_header(flow_header(k, cmac, smac, 1'b1, FLG_SYN));
            npush = $urandom_range(0, 4);
            for (int p = 0; p < npush; p++)
                send_header(flow_header(k, cmac, smac, 1'($urandom_range(0, 1)),
                                        FLG_PSH | FLG_ACK));
            if ($urandom_range(0, 9) == 0)
                send_header(random_header());
            if ($urandom_range(0, 11) != 0)
                send_header(flow_header(k, cmac, smac, 1'($urandom_range(0, 1)),
                                        $urandom_range(0, 1) ? FLG_RST : (FLG_FIN | FLG_ACK)));
        end
        no_idle = 0;
    endtask

    // Record side: random stalls and a field-by-field compare against the oldest expectation.
    always @(negedge clk)
    begin
        if (no_idle)
            rec.ready <= 1'b1;
        else
            rec.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50);
    end

    always @(posedge clk)
    begin
        flow_rec_t e;
        if (rst_n && rec.valid && rec.ready)
        begin
            if (expected_records.size() == 0)
            begin
                $error("record with no expectation waiting: kind %0d", rec.record_kind);
                error_count++;
            end
            else
            begin
                e = expected_records.pop_front();
                if (rec.record_kind !== e.record_kind)
                begin
                    $error("record_kind exp %0d got %0d", e.record_kind, rec.record_kind);
                    error_count++;
                end
                if (rec.client_mac !== e.client_mac)
                begin
                    $error("client_mac exp %h got %h", e.client_mac, rec.client_mac);
                    error_count++;
                end
                if (rec.client_address !== e.client_address)
                begin
                    $error("client_address exp %h got %h", e.client_address, rec.client_address);
                    error_count++;
                end
                if (rec.server_address !== e.server_address)
                begin
                    $error("server_address exp %h got %h", e.server_address, rec.server_address);
                    error_count++;
                end
                if (rec.client_side_port !== e.client_side_port)
                begin
                    $error("client_side_port exp %h got %h", e.client_side_port,
                           rec.client_side_port);
                    error_count++;
                end
                if (rec.server_side_port !== e.server_side_port)
                begin
                    $error("server_side_port exp %h got %h", e.server_side_port,
                           rec.server_side_port);
                    error_count++;
                end
                if (rec.start_seconds !== e.start_seconds)
                begin
                    $error("start_seconds exp %h got %h", e.start_seconds, rec.start_seconds);
                    error_count++;
                end
                if (rec.end_seconds !== e.end_seconds)
                begin
                    $error("end_seconds exp %h got %h", e.end_seconds, rec.end_seconds);
                    error_count++;
                end
                if (rec.byte_total !== e.byte_total)
                begin
                    $error("byte_total exp %h got %h", e.byte_total, rec.byte_total);
                    error_count++;
                end
                if (rec.packet_total !== e.packet_total)
                begin
                    $error("packet_total exp %h got %h", e.packet_total, rec.packet_total);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pkt.valid && pkt.ready) || (rec.valid && rec.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        quiet_cycles = 0;
        no_idle = 0;
        port_threshold = DEF_CLIENT_PORT_THRESHOLD;
        hs_flags = '0;
        for (int i = 0; i < ENTRIES; i++)
            slot_used[i] = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        pkt.valid = 1'b0;
        pkt.source_mac = '0;
        pkt.destination_mac = '0;
        pkt.source_ip = '0;
        pkt.destination_ip = '0;
        pkt.source_port = '0;
        pkt.destination_port = '0;
        pkt.tcp_flags = '0;
        pkt.captured_length = '0;
        pkt.timestamp_seconds = '0;
        rec.ready = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_random_flows(20);
        write_threshold(16'hffff);
        test_random_flows(10);
        write_threshold(16'h0000);
        test_random_flows(10);
        write_threshold(16'($urandom));
        test_random_flows(10);
        write_threshold(DEF_CLIENT_PORT_THRESHOLD);
        test_random_flows(18);
        wait_idle();

        if (error_count == 0 && expected_records.size() == 0)
            $display("status: pass");
        else
        begin
            if (expected_records.size() != 0)
                $error("%0d expected records never arrived", expected_records.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
